### hw/rtl/owrs_pkg.sv
`timescale 1ns / 1ps
// Package for the one-wire ROM search engine.
// Holds the item types, status and action codes, command bytes and sizes.
// It depends on nothing else.
package owrs_pkg;

	localparam int ID_BITS = 64;
	localparam int POS_W   = $clog2(ID_BITS + 1);
	localparam int IDX_W   = $clog2(ID_BITS);
	localparam int ROM_W   = 64;

	localparam logic [7:0] CMD_SEARCH_ROM   = 8'hf0;
	localparam logic [7:0] CMD_SEARCH_ALARM = 8'hec;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ONLY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVICES = 2'd1;

	localparam logic [1:0] ACT_NEW_SEARCH = 2'd0;
	localparam logic [1:0] ACT_PASS_START = 2'd1;
	localparam logic [1:0] ACT_BIT_PAIR   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEARED      = 3'd0,
		ST_PASS_STARTED = 3'd1,
		ST_DIRECTION    = 3'd2,
		ST_FOUND        = 3'd3,
		ST_DONE         = 3'd4,
		ST_NO_DEVICES   = 3'd5,
		ST_BUS_ERROR    = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0] action;
		logic       presence;
		logic       id_bit;
		logic       complement_bit;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       command_byte;
		logic             direction;
		logic [ROM_W-1:0] rom_code;
		logic [7:0]       device_index;
		logic [7:0]       device_count;
	} out_item_t;

	typedef struct packed {
		logic       alarm_only;
		logic [7:0] max_devices;
	} cfg_t;

	typedef struct packed {
		logic [ID_BITS-1:0] path_bits;
		logic [POS_W-1:0]   bit_position;
		logic [POS_W-1:0]   last_discrepancy;
		logic [POS_W-1:0]   last_zero_position;
		logic               last_device_seen;
		logic [7:0]         found_count;
		logic               pass_active;
	} search_state_t;

endpackage

### hw/rtl/owrs_step.sv
`timescale 1ns / 1ps
// Decision logic of the ROM search: one item against the current search state.
// Gives the next state and the result item. Uses owrs_pkg.
module owrs_step (
	input  owrs_pkg::cfg_t          cfg,
	input  owrs_pkg::search_state_t cur,
	input  owrs_pkg::in_item_t      item,
	output owrs_pkg::search_state_t nxt,
	output logic                    res_valid,
	output owrs_pkg::out_item_t     res
);

	logic [owrs_pkg::POS_W-1:0] n;
	logic [owrs_pkg::IDX_W-1:0] idx;
	logic                       dir;

	always_comb begin
		nxt       = cur;
		res       = '0;
		res.status = owrs_pkg::ST_CLEARED;
		res_valid = 1'b1;
		n         = cur.bit_position + owrs_pkg::POS_W'(1);
		idx       = cur.bit_position[owrs_pkg::IDX_W-1:0];
		dir       = 1'b0;
		case (item.action)
			owrs_pkg::ACT_NEW_SEARCH: begin
				nxt = '0;
				res.status = owrs_pkg::ST_CLEARED;
			end
			owrs_pkg::ACT_PASS_START: begin
				if (cur.found_count >= cfg.max_devices || cur.last_device_seen) begin
					nxt.pass_active = 1'b0;
					res.status = owrs_pkg::ST_DONE;
				end else if (!item.presence) begin
					nxt = '0;
					res.status = owrs_pkg::ST_NO_DEVICES;
				end else begin
					nxt.bit_position       = '0;
					nxt.last_zero_position = '0;
					nxt.pass_active        = 1'b1;
					res.status = owrs_pkg::ST_PASS_STARTED;
					res.command_byte = cfg.alarm_only ? owrs_pkg::CMD_SEARCH_ALARM
						: owrs_pkg::CMD_SEARCH_ROM;
				end
			end
			owrs_pkg::ACT_BIT_PAIR: begin
				if (!cur.pass_active ||
					cur.bit_position >= owrs_pkg::POS_W'(owrs_pkg::ID_BITS)) begin
					res_valid = 1'b0;
				end else if (item.id_bit && item.complement_bit) begin
					nxt = '0;
					res.status = owrs_pkg::ST_BUS_ERROR;
				end else begin
					if (item.id_bit != item.complement_bit) begin
						dir = item.id_bit;
					end else begin
						if (n < cur.last_discrepancy) begin
							dir = cur.path_bits[idx];
						end else if (n == cur.last_discrepancy) begin
							dir = 1'b1;
						end else begin
							dir = 1'b0;
						end
						if (!dir) begin
							nxt.last_zero_position = n;
						end
					end
					nxt.path_bits[idx] = dir;
					nxt.bit_position   = n;
					res.direction      = dir;
					res.status = owrs_pkg::ST_DIRECTION;
					if (n == owrs_pkg::POS_W'(owrs_pkg::ID_BITS)) begin
						nxt.last_discrepancy = nxt.last_zero_position;
						if (nxt.last_zero_position == '0) begin
							nxt.last_device_seen = 1'b1;
						end
						res.device_index = cur.found_count;
						if (cur.found_count != 8'hff) begin
							nxt.found_count = cur.found_count + 8'd1;
						end
						res.rom_code    = owrs_pkg::ROM_W'(nxt.path_bits);
						nxt.pass_active = 1'b0;
						res.status = owrs_pkg::ST_FOUND;
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
		res.device_count = nxt.found_count;
	end

endmodule

### hw/rtl/onewire_rom_search_engine_core.sv
`timescale 1ns / 1ps
// Top level of the one-wire ROM search engine: input register, search state,
// result register and configuration registers. Uses owrs_pkg and owrs_step.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid / in_stall    | in_item  (owrs_pkg::in_item_t)
//   out      | out_valid / out_stall  | out_item (owrs_pkg::out_item_t)
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An accepted item passes through the input register and then the result
// register. One item is accepted every cycle while in_stall is low.
// Reset clears the search state and loads alarm_only 0, max_devices 255.
// A stall on the output holds the result register and, through it, the
// input register; bit pairs outside a pass give no result.
module onewire_rom_search_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  owrs_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output owrs_pkg::out_item_t               out_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [owrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);

	logic                    valid_s1;
	owrs_pkg::in_item_t      item_s1;
	logic                    out_valid_q;
	owrs_pkg::out_item_t     out_item_q;
	owrs_pkg::cfg_t          cfg_q;
	owrs_pkg::search_state_t state_q;
	owrs_pkg::search_state_t state_nxt;
	logic                    res_valid;
	owrs_pkg::out_item_t     res;
	logic                    advance;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	owrs_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.item      (item_s1),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_only  <= 1'b0;
			cfg_q.max_devices <= 8'd255;
		end else if (cfg_valid) begin
			case (cfg_index)
				owrs_pkg::CFG_ALARM_ONLY:  cfg_q.alarm_only  <= cfg_data[0];
				owrs_pkg::CFG_MAX_DEVICES: cfg_q.max_devices <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res_valid;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (advance && valid_s1) begin
			out_item_q <= res;
		end
	end

	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.status == owrs_pkg::ST_FOUND |->
		out_item_q.device_count == out_item_q.device_index + 8'd1 ||
		(out_item_q.device_index == 8'hff && out_item_q.device_count == 8'hff))
		else $error("device count does not follow the found index");

	a_rom_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.status != owrs_pkg::ST_FOUND |->
		out_item_q.rom_code == '0)
		else $error("rom code shown outside a found result");

	a_active_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pass_active |->
		state_q.bit_position < owrs_pkg::POS_W'(owrs_pkg::ID_BITS))
		else $error("pass active past the last bit");

	a_last_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.last_device_seen |-> state_q.last_discrepancy == '0)
		else $error("last device flagged with a discrepancy left");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.status == owrs_pkg::ST_CLEARED ||
		out_item_q.status == owrs_pkg::ST_BUS_ERROR) |->
		out_item_q.device_count == 8'd0)
		else $error("count not cleared with the search");

endmodule
